FILE: hw/rtl/csw_pkg.sv
// ----------------------------------------------------------------------------
// Cosine-sum window generator package
// Widths, window weights, gains and series constants shared by the block.
// ----------------------------------------------------------------------------
package csw_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned MAX_LENGTH = 4096;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned TYPE_W     = 3;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned NUM_TERMS  = 4;
  localparam int unsigned Q_FRAC     = 30;
  localparam int unsigned COS_W      = 32;
  localparam int unsigned WGT_W      = 32;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned SERIES_LEN = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;
  localparam logic [LEN_W-1:0]     LEN_RESET         = 13'd1024;

  // Fractional part of pi over two in Q32; the integer part of one is added apart.
  localparam logic [31:0] TWO_PI_FRAC = 32'h921F_B544;

  typedef enum logic [TYPE_W-1:0] {
    WIN_NONE            = 3'd0,
    WIN_FLAT_TOP        = 3'd1,
    WIN_BLACKMAN_HARRIS = 3'd2,
    WIN_HANN            = 3'd3,
    WIN_BLACKMAN        = 3'd4
  } win_type_e;

  typedef logic [WGT_W-1:0] wgt_t;
  typedef wgt_t [NUM_TERMS:0] wgt_set_t;

  localparam longint QONE = 64'sd1 <<< Q_FRAC;

  localparam longint W_FT0 = ((64'sd215578948 <<< 30) + 64'sd500000000) / 64'sd1000000000;
  localparam longint W_FT1 = ((64'sd416631580 <<< 30) + 64'sd500000000) / 64'sd1000000000;
  localparam longint W_FT2 = ((64'sd277263158 <<< 30) + 64'sd500000000) / 64'sd1000000000;
  localparam longint W_FT3 = ((64'sd83578947 <<< 30) + 64'sd500000000) / 64'sd1000000000;
  localparam longint W_FT4 = ((64'sd6947368 <<< 30) + 64'sd500000000) / 64'sd1000000000;
  localparam longint W_BH0 = ((64'sd42323 <<< 30) + 64'sd50000) / 64'sd100000;
  localparam longint W_BH1 = ((64'sd49755 <<< 30) + 64'sd50000) / 64'sd100000;
  localparam longint W_BH2 = ((64'sd7922 <<< 30) + 64'sd50000) / 64'sd100000;
  localparam longint W_HN0 = ((64'sd1 <<< 30) + 64'sd1) / 64'sd2;
  localparam longint W_BK0 = ((64'sd42 <<< 30) + 64'sd50) / 64'sd100;
  localparam longint W_BK1 = ((64'sd50 <<< 30) + 64'sd50) / 64'sd100;
  localparam longint W_BK2 = ((64'sd8 <<< 30) + 64'sd50) / 64'sd100;

  localparam int unsigned GAIN_SH = Q_FRAC - FRAC_BITS;
  localparam longint GAIN_HALF = 64'sd1 <<< (GAIN_SH - 1);

  function automatic wgt_set_t weights_of(input logic [TYPE_W-1:0] wt);
    wgt_set_t w;
    w = '0;
    case (wt)
      WIN_NONE: begin
        w[0] = WGT_W'(QONE);
      end
      WIN_FLAT_TOP: begin
        w[0] = WGT_W'(W_FT0);
        w[1] = WGT_W'(-W_FT1);
        w[2] = WGT_W'(W_FT2);
        w[3] = WGT_W'(-W_FT3);
        w[4] = WGT_W'(W_FT4);
      end
      WIN_BLACKMAN_HARRIS: begin
        w[0] = WGT_W'(W_BH0);
        w[1] = WGT_W'(-W_BH1);
        w[2] = WGT_W'(W_BH2);
      end
      WIN_HANN: begin
        w[0] = WGT_W'(W_HN0);
        w[1] = WGT_W'(-W_HN0);
      end
      WIN_BLACKMAN: begin
        w[0] = WGT_W'(W_BK0);
        w[1] = WGT_W'(-W_BK1);
        w[2] = WGT_W'(W_BK2);
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_of(input logic [TYPE_W-1:0] wt);
    case (wt)
      WIN_FLAT_TOP:        return GAIN_W'((W_FT0 + GAIN_HALF) >>> GAIN_SH);
      WIN_BLACKMAN_HARRIS: return GAIN_W'((W_BH0 + GAIN_HALF) >>> GAIN_SH);
      WIN_HANN:            return GAIN_W'((W_HN0 + GAIN_HALF) >>> GAIN_SH);
      WIN_BLACKMAN:        return GAIN_W'((W_BK0 + GAIN_HALF) >>> GAIN_SH);
      default:             return GAIN_W'((QONE + GAIN_HALF) >>> GAIN_SH);
    endcase
  endfunction

  function automatic logic [7:0] series_fac(input int unsigned k);
    return 8'((2 * k) * (2 * k - 1));
  endfunction

  function automatic logic [31:0] series_recip(input int unsigned k);
    case (k)
      1:       return 32'((64'd1 << 32) / 64'd2);
      2:       return 32'((64'd1 << 32) / 64'd12);
      3:       return 32'((64'd1 << 32) / 64'd30);
      4:       return 32'((64'd1 << 32) / 64'd56);
      5:       return 32'((64'd1 << 32) / 64'd90);
      6:       return 32'((64'd1 << 32) / 64'd132);
      7:       return 32'((64'd1 << 32) / 64'd182);
      8:       return 32'((64'd1 << 32) / 64'd240);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/csw_phase.sv
// ----------------------------------------------------------------------------
// Cosine-sum window phase unit
// Pipelined remainder of the index by the length and pipelined division of
// each harmonic's remainder into a 32-bit fraction of a turn.
// ----------------------------------------------------------------------------
module csw_phase import csw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [IDX_W-1:0]   index_i,
  input  logic [LEN_W-1:0]   len_i,
  output logic               valid_o,
  output logic [PHASE_W-1:0] phase_o [NUM_TERMS]
);

  localparam int unsigned MOD_STEPS  = 4;
  localparam int unsigned MOD_STAGES = IDX_W / MOD_STEPS;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = PHASE_W / DIV_STEPS;

  logic             len_zero;
  logic [LEN_W:0]   len_ext;

  logic [LEN_W-1:0] mrem_q  [MOD_STAGES];
  logic [IDX_W-1:0] mbits_q [MOD_STAGES];
  logic             mvld_q  [MOD_STAGES];

  logic [LEN_W-1:0] mul_d [NUM_TERMS];
  logic [LEN_W-1:0] mul_q [NUM_TERMS];
  logic             mul_vld_q;

  logic [LEN_W-1:0]   drem_q [DIV_STAGES][NUM_TERMS];
  logic [PHASE_W-1:0] dquo_q [DIV_STAGES][NUM_TERMS];
  logic               dvld_q [DIV_STAGES];

  assign len_zero = (len_i == '0);
  assign len_ext  = {1'b0, len_i};

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    logic [LEN_W-1:0] rem_in;
    logic [LEN_W-1:0] rem_d;
    logic [IDX_W-1:0] bits_in;
    logic [IDX_W-1:0] bits_d;
    logic             vld_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign bits_in = index_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = mrem_q[s-1];
      assign bits_in = mbits_q[s-1];
      assign vld_in  = mvld_q[s-1];
    end

    always_comb begin
      logic [LEN_W:0] t;
      rem_d  = rem_in;
      bits_d = bits_in;
      for (int i = 0; i < MOD_STEPS; i++) begin
        t      = {rem_d, bits_d[IDX_W-1]};
        bits_d = {bits_d[IDX_W-2:0], 1'b0};
        if (t >= len_ext) begin
          t = t - len_ext;
        end
        rem_d = t[LEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mvld_q[s] <= 1'b0;
      end else if (en_i) begin
        mvld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mrem_q[s]  <= rem_d;
        mbits_q[s] <= bits_d;
      end
    end
  end

  // Remainders of the higher harmonics follow from the first by adding.
  always_comb begin
    logic [LEN_W:0]   t2;
    logic [LEN_W:0]   t3;
    logic [LEN_W:0]   t4;
    logic [LEN_W-1:0] r1;
    logic [LEN_W-1:0] r2;
    r1 = mrem_q[MOD_STAGES-1];
    t2 = {r1, 1'b0};
    if (t2 >= len_ext) begin
      t2 = t2 - len_ext;
    end
    r2 = t2[LEN_W-1:0];
    t3 = {1'b0, r1} + {1'b0, r2};
    if (t3 >= len_ext) begin
      t3 = t3 - len_ext;
    end
    t4 = {r2, 1'b0};
    if (t4 >= len_ext) begin
      t4 = t4 - len_ext;
    end
    mul_d[0] = r1;
    mul_d[1] = r2;
    mul_d[2] = t3[LEN_W-1:0];
    mul_d[3] = t4[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en_i) begin
      mul_vld_q <= mvld_q[MOD_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= mul_d;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic vld_in;

    if (s == 0) begin : g_first_vld
      assign vld_in = mul_vld_q;
    end else begin : g_next_vld
      assign vld_in = dvld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[s] <= 1'b0;
      end else if (en_i) begin
        dvld_q[s] <= vld_in;
      end
    end

    for (genvar l = 0; l < NUM_TERMS; l++) begin : g_lane
      logic [LEN_W-1:0]   rem_in;
      logic [LEN_W-1:0]   rem_d;
      logic [PHASE_W-1:0] quo_in;
      logic [PHASE_W-1:0] quo_d;

      if (s == 0) begin : g_first
        assign rem_in = mul_q[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = drem_q[s-1][l];
        assign quo_in = dquo_q[s-1][l];
      end

      always_comb begin
        logic [LEN_W:0] t;
        logic           bit_q;
        rem_d = rem_in;
        quo_d = quo_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
          t     = {rem_d, 1'b0};
          bit_q = (t >= len_ext);
          if (bit_q) begin
            t = t - len_ext;
          end
          rem_d = t[LEN_W-1:0];
          quo_d = {quo_d[PHASE_W-2:0], bit_q};
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          drem_q[s][l] <= rem_d;
          dquo_q[s][l] <= quo_d;
        end
      end
    end
  end

  assign valid_o = dvld_q[DIV_STAGES-1];

  for (genvar l = 0; l < NUM_TERMS; l++) begin : g_out
    assign phase_o[l] = len_zero ? '0 : dquo_q[DIV_STAGES-1][l];
  end

endmodule

FILE: hw/rtl/csw_cosine.sv
// ----------------------------------------------------------------------------
// Cosine-sum window cosine unit
// Quadrant folding, conversion to radians and a pipelined nested series for
// the cosine of each harmonic phase, in Q30.
// ----------------------------------------------------------------------------
module csw_cosine import csw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [PHASE_W-1:0]      phase_i [NUM_TERMS],
  output logic                    valid_o,
  output logic signed [COS_W-1:0] cos_o   [NUM_TERMS]
);

  localparam int unsigned MAG_W = PHASE_W - 1;
  localparam int unsigned S_W   = Q_FRAC + 1;
  localparam logic [S_W-1:0] S_ONE = S_W'(1) << Q_FRAC;

  logic [MAG_W-1:0] fmag_q  [NUM_TERMS];
  logic             fneg_q  [NUM_TERMS];
  logic             fvld_q;
  logic [MAG_W-1:0] x_q     [NUM_TERMS];
  logic             xneg_q  [NUM_TERMS];
  logic             xvld_q;
  logic [31:0]      x2_q    [NUM_TERMS];
  logic             x2neg_q [NUM_TERMS];
  logic             x2vld_q;

  logic [31:0]    a_p_q   [SERIES_LEN][NUM_TERMS];
  logic [31:0]    a_x2_q  [SERIES_LEN][NUM_TERMS];
  logic           a_neg_q [SERIES_LEN][NUM_TERMS];
  logic           a_vld_q [SERIES_LEN];
  logic [31:0]    b_p_q   [SERIES_LEN][NUM_TERMS];
  logic [31:0]    b_q_q   [SERIES_LEN][NUM_TERMS];
  logic [31:0]    b_x2_q  [SERIES_LEN][NUM_TERMS];
  logic           b_neg_q [SERIES_LEN][NUM_TERMS];
  logic           b_vld_q [SERIES_LEN];
  logic [S_W-1:0] c_s_q   [SERIES_LEN][NUM_TERMS];
  logic [31:0]    c_x2_q  [SERIES_LEN][NUM_TERMS];
  logic           c_neg_q [SERIES_LEN][NUM_TERMS];
  logic           c_vld_q [SERIES_LEN];

  logic signed [COS_W-1:0] cos_q [NUM_TERMS];
  logic                    ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q  <= 1'b0;
      xvld_q  <= 1'b0;
      x2vld_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else if (en_i) begin
      fvld_q  <= valid_i;
      xvld_q  <= fvld_q;
      x2vld_q <= xvld_q;
      ovld_q  <= c_vld_q[SERIES_LEN-1];
    end
  end

  for (genvar l = 0; l < NUM_TERMS; l++) begin : g_front
    logic [PHASE_W-1:0] b;
    logic [PHASE_W:0]   mag_full;
    logic               neg_d;
    logic [62:0]        xprod;
    logic [61:0]        sq;

    // The middle two quadrants are shifted by half a turn and negated.
    assign neg_d    = phase_i[l][PHASE_W-1] ^ phase_i[l][PHASE_W-2];
    assign b        = neg_d ? (phase_i[l] ^ {1'b1, {(PHASE_W-1){1'b0}}}) : phase_i[l];
    assign mag_full = b[PHASE_W-1] ? ({1'b1, {PHASE_W{1'b0}}} - {1'b0, b}) : {1'b0, b};
    assign xprod    = 63'(fmag_q[l]) * 63'(TWO_PI_FRAC);
    assign sq       = 62'(x_q[l]) * 62'(x_q[l]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fmag_q[l]  <= mag_full[MAG_W-1:0];
        fneg_q[l]  <= neg_d;
        x_q[l]     <= MAG_W'({1'b0, fmag_q[l]} + {1'b0, xprod[62:32]});
        xneg_q[l]  <= fneg_q[l];
        x2_q[l]    <= sq[61:30];
        x2neg_q[l] <= xneg_q[l];
      end
    end
  end

  for (genvar i = 0; i < SERIES_LEN; i++) begin : g_iter
    localparam int unsigned  K     = SERIES_LEN - i;
    localparam logic [7:0]   FAC   = series_fac(K);
    localparam logic [31:0]  RECIP = series_recip(K);

    logic vld_in;

    if (i == 0) begin : g_first_vld
      assign vld_in = x2vld_q;
    end else begin : g_next_vld
      assign vld_in = c_vld_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[i] <= 1'b0;
        b_vld_q[i] <= 1'b0;
        c_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        a_vld_q[i] <= vld_in;
        b_vld_q[i] <= a_vld_q[i];
        c_vld_q[i] <= b_vld_q[i];
      end
    end

    for (genvar l = 0; l < NUM_TERMS; l++) begin : g_lane
      logic [31:0]    x2_in;
      logic [S_W-1:0] s_in;
      logic           neg_in;
      logic [61:0]    pprod;
      logic [63:0]    qprod;
      logic [S_W-1:0] s_d;

      if (i == 0) begin : g_first
        assign x2_in  = x2_q[l];
        assign s_in   = S_ONE;
        assign neg_in = x2neg_q[l];
      end else begin : g_next
        assign x2_in  = c_x2_q[i-1][l];
        assign s_in   = c_s_q[i-1][l];
        assign neg_in = c_neg_q[i-1][l];
      end

      assign pprod = 62'(x2_in) * 62'(s_in);
      assign qprod = 64'(a_p_q[i][l]) * 64'(RECIP);

      // The reciprocal estimate is at most one short of the true quotient.
      always_comb begin
        logic [39:0] prodf;
        logic [39:0] remv;
        logic [32:0] d;
        prodf = 40'(b_q_q[i][l]) * 40'(FAC);
        remv  = {8'b0, b_p_q[i][l]} - prodf;
        if (remv >= 40'(FAC)) begin
          d = {1'b0, b_q_q[i][l]} + 33'd1;
        end else begin
          d = {1'b0, b_q_q[i][l]};
        end
        if (d >= 33'(S_ONE)) begin
          s_d = '0;
        end else begin
          s_d = S_W'(33'(S_ONE) - d);
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_p_q[i][l]   <= pprod[61:30];
          a_x2_q[i][l]  <= x2_in;
          a_neg_q[i][l] <= neg_in;
          b_p_q[i][l]   <= a_p_q[i][l];
          b_q_q[i][l]   <= qprod[63:32];
          b_x2_q[i][l]  <= a_x2_q[i][l];
          b_neg_q[i][l] <= a_neg_q[i][l];
          c_s_q[i][l]   <= s_d;
          c_x2_q[i][l]  <= b_x2_q[i][l];
          c_neg_q[i][l] <= b_neg_q[i][l];
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_TERMS; l++) begin : g_out
    logic signed [COS_W-1:0] s_ext;

    assign s_ext = $signed(COS_W'(c_s_q[SERIES_LEN-1][l]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cos_q[l] <= c_neg_q[SERIES_LEN-1][l] ? -s_ext : s_ext;
      end
    end

    assign cos_o[l] = cos_q[l];
  end

  assign valid_o = ovld_q;

endmodule

FILE: hw/rtl/csw_combine.sv
// ----------------------------------------------------------------------------
// Cosine-sum window combiner
// Weights each harmonic cosine, sums the terms and rounds and saturates the
// result to the coefficient format; attaches the coherent gain.
// ----------------------------------------------------------------------------
module csw_combine import csw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [COS_W-1:0]  cos_i [NUM_TERMS],
  input  logic [TYPE_W-1:0]        win_type_i,
  output logic                     valid_o,
  output logic signed [COEF_W-1:0] coefficient_o,
  output logic [GAIN_W-1:0]        window_gain_o
);

  localparam int unsigned ROUND_SH = 2 * Q_FRAC - FRAC_BITS;
  localparam int unsigned ROUND_W  = SUM_W - ROUND_SH + 1;
  localparam logic [ROUND_W-1:0] MAG_POS_MAX = ROUND_W'((1 << (COEF_W - 1)) - 1);
  localparam logic [ROUND_W-1:0] MAG_NEG_MAX = ROUND_W'(1 << (COEF_W - 1));
  localparam logic signed [COEF_W-1:0] COEF_MAX = COEF_W'((1 << (COEF_W - 1)) - 1);
  localparam logic signed [COEF_W-1:0] COEF_MIN = COEF_W'(1 << (COEF_W - 1));

  wgt_set_t                wgt_q;
  logic signed [SUM_W-1:0] prod_q [NUM_TERMS+1];
  logic signed [SUM_W-1:0] sa_q;
  logic signed [SUM_W-1:0] sb_q;
  logic signed [SUM_W-1:0] sc_q;
  logic signed [SUM_W-1:0] st_q;
  logic signed [SUM_W-1:0] sc2_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]        mag_q;
  logic                    sgn_q;
  logic signed [COEF_W-1:0] coef_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [5:0]              vld_q;

  logic [SUM_W:0]           rnd;
  logic [ROUND_W-1:0]       rmag;
  logic signed [COEF_W-1:0] coef_d;

  always_ff @(posedge clk_i) begin
    wgt_q <= weights_of(win_type_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  for (genvar j = 0; j <= NUM_TERMS; j++) begin : g_prod
    logic signed [SUM_W-1:0] prod_d;

    if (j == 0) begin : g_base
      assign prod_d = $signed({{(SUM_W-WGT_W-Q_FRAC){wgt_q[0][WGT_W-1]}}, wgt_q[0],
                               {Q_FRAC{1'b0}}});
    end else begin : g_term
      assign prod_d = $signed(wgt_q[j]) * cos_i[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[j] <= prod_d;
      end
    end
  end

  assign rnd  = {1'b0, mag_q} + ((SUM_W+1)'(1) << (ROUND_SH - 1));
  assign rmag = rnd[SUM_W:ROUND_SH];

  always_comb begin
    if (sgn_q) begin
      if (rmag > MAG_NEG_MAX) begin
        coef_d = COEF_MIN;
      end else begin
        coef_d = -$signed(rmag[COEF_W-1:0]);
      end
    end else begin
      if (rmag > MAG_POS_MAX) begin
        coef_d = COEF_MAX;
      end else begin
        coef_d = $signed(rmag[COEF_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= prod_q[0] + prod_q[1];
      sb_q   <= prod_q[2] + prod_q[3];
      sc_q   <= prod_q[4];
      st_q   <= sa_q + sb_q;
      sc2_q  <= sc_q;
      sum_q  <= st_q + sc2_q;
      sgn_q  <= sum_q[SUM_W-1];
      mag_q  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      coef_q <= coef_d;
      gain_q <= gain_of(win_type_i);
    end
  end

  assign valid_o       = vld_q[5];
  assign coefficient_o = coef_q;
  assign window_gain_o = gain_q;

endmodule

FILE: hw/rtl/cosine_sum_window_generator_core.sv
// ----------------------------------------------------------------------------
// Cosine-sum window generator core
// Gives the window coefficient w(n) of the configured cosine-sum window for
// each sample index, with the coherent gain of the window type.
// ----------------------------------------------------------------------------
// The block takes one sample index in every clock cycle while the output is
// not stalled and delivers one coefficient item per index, in order; a stall
// on the output holds the whole pipeline: the phase unit (three stages for the
// remainder of the index by the length, one for the harmonics and eight for
// the division that turns each harmonic's remainder into a phase, four bits a
// stage), the cosine unit with its eight-term series, three stages a term, run
// in parallel for the four harmonics, and six stages that weight, sum and
// round. The user must write window type and length only while no item is in
// flight; the block does not enforce it. A length above the maximum is used
// as the maximum, and a length of zero gives every harmonic a phase of zero.
module cosine_sum_window_generator_core import csw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [IDX_W-1:0]         sample_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [COEF_W-1:0] coefficient_o,
  output logic [GAIN_W-1:0]        window_gain_o
);

  localparam logic [16:0] MAX_LEN_CMP = 17'(MAX_LENGTH);

  logic [TYPE_W-1:0] win_type_q;
  logic [LEN_W-1:0]  win_len_q;
  logic [LEN_W-1:0]  len_eff;
  logic              en;

  logic               ph_valid;
  logic [PHASE_W-1:0] phase [NUM_TERMS];
  logic               cos_valid;
  logic signed [COS_W-1:0] cos_val [NUM_TERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_type_q <= WIN_NONE;
      win_len_q  <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_TYPE:   win_type_q <= cfg_wdata_i[TYPE_W-1:0];
        REG_WINDOW_LENGTH: win_len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign len_eff    = ({4'b0, win_len_q} > MAX_LEN_CMP) ? LEN_W'(MAX_LENGTH) : win_len_q;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  csw_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .index_i (sample_index_i),
    .len_i   (len_eff),
    .valid_o (ph_valid),
    .phase_o (phase)
  );

  csw_cosine u_cosine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .phase_i (phase),
    .valid_o (cos_valid),
    .cos_o   (cos_val)
  );

  csw_combine u_combine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (cos_valid),
    .cos_i         (cos_val),
    .win_type_i    (win_type_q),
    .valid_o       (out_valid_o),
    .coefficient_o (coefficient_o),
    .window_gain_o (window_gain_o)
  );

endmodule

FILE: sim/csw_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window checker
// Watches the configuration port and both channels of the window generator,
// works out the coefficient and coherent gain of every accepted sample index
// and compares them, in order, with the items that leave the block.
// ----------------------------------------------------------------------------
module csw_window_checker import csw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [IDX_W-1:0]         sample_index_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [COEF_W-1:0] coefficient_i,
  input  logic [GAIN_W-1:0]        window_gain_i,
  output int                       error_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [GAIN_W-1:0]        gain;
  } window_value_t;

  localparam longint unsigned ONE_Q = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q = 64'h1_921F_B544;

  logic [TYPE_W-1:0] win_type;
  logic [LEN_W-1:0]  win_len;
  window_value_t     expected_q[$];

  function automatic longint signed frac_q30(longint unsigned num, longint unsigned den);
    return longint'(((num << 30) + den / 2) / den);
  endfunction

  function automatic longint signed weight(logic [TYPE_W-1:0] wt, int j);
    longint signed w[5];
    w = '{0, 0, 0, 0, 0};
    case (wt)
      WIN_NONE: w[0] = longint'(ONE_Q);
      WIN_FLAT_TOP: begin
        w[0] = frac_q30(215578948, 1000000000);
        w[1] = -frac_q30(416631580, 1000000000);
        w[2] = frac_q30(277263158, 1000000000);
        w[3] = -frac_q30(83578947, 1000000000);
        w[4] = frac_q30(6947368, 1000000000);
      end
      WIN_BLACKMAN_HARRIS: begin
        w[0] = frac_q30(42323, 100000);
        w[1] = -frac_q30(49755, 100000);
        w[2] = frac_q30(7922, 100000);
      end
      WIN_HANN: begin
        w[0] = frac_q30(1, 2);
        w[1] = -frac_q30(1, 2);
      end
      WIN_BLACKMAN: begin
        w[0] = frac_q30(42, 100);
        w[1] = -frac_q30(50, 100);
        w[2] = frac_q30(8, 100);
      end
      default: ;
    endcase
    return w[j];
  endfunction

  function automatic longint signed cosine_q30(logic [31:0] phase);
    logic [1:0]      quad;
    logic            neg;
    logic [31:0]     b;
    longint unsigned mag, x, x2, s, d;
    quad = phase[31:30];
    neg = (quad == 2'd1) || (quad == 2'd2);
    b = neg ? phase + 32'h8000_0000 : phase;
    mag = (b < 32'h8000_0000) ? 64'(b) : (64'd1 << 32) - 64'(b);
    x = (mag * TWO_PI_Q) >> 32;
    x2 = (x * x) >> 30;
    s = ONE_Q;
    for (int k = 8; k >= 1; k--) begin
      d = ((x2 * s) >> 30) / longint'((2 * k) * (2 * k - 1));
      s = (d >= ONE_Q) ? 64'd0 : ONE_Q - d;
    end
    return neg ? -longint'(s) : longint'(s);
  endfunction

  function automatic window_value_t window_at(logic [IDX_W-1:0] n);
    window_value_t   v;
    longint unsigned len, r, mag, g;
    longint signed   sum;
    logic [31:0]     phase;
    len = (win_len > MAX_LENGTH) ? MAX_LENGTH : win_len;
    if (win_type > WIN_BLACKMAN) begin
      v.coefficient = '0;
      g = (ONE_Q + (64'd1 << 13)) >> 14;
    end else begin
      sum = weight(win_type, 0) * longint'(ONE_Q);
      for (int j = 1; j < 5; j++) begin
        phase = '0;
        if (len != 0) begin
          r = (longint'(j) * n) % len;
          phase = 32'((r << 32) / len);
        end
        sum += weight(win_type, j) * cosine_q30(phase);
      end
      mag = (sum < 0) ? -sum : sum;
      r = (mag + (64'd1 << 43)) >> 44;
      if (sum < 0) v.coefficient = (r > 131072) ? -18'sd131072 : COEF_W'(-longint'(r));
      else v.coefficient = (r > 131071) ? 18'sd131071 : COEF_W'(r);
      g = (((win_type == WIN_NONE) ? ONE_Q : weight(win_type, 0)) + (64'd1 << 13)) >> 14;
    end
    v.gain = (g > 131071) ? 17'd131071 : GAIN_W'(g);
    return v;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    window_value_t e;
    int            errs;
    if (!rst_ni) begin
      win_type <= WIN_NONE;
      win_len <= LEN_RESET;
      error_count_o <= 0;
      expected_q.delete();
    end else begin
      errs = 0;
      if (cfg_we_i && cfg_idx_i == REG_WINDOW_TYPE) win_type <= cfg_wdata_i[TYPE_W-1:0];
      if (cfg_we_i && cfg_idx_i == REG_WINDOW_LENGTH) win_len <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_q.push_back(window_at(sample_index_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: coefficient %0d window_gain %0d", coefficient_i,
                 window_gain_i);
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (coefficient_i !== e.coefficient) begin
            $error("coefficient: expected %0d, actual %0d", e.coefficient, coefficient_i);
            errs = errs + 1;
          end
          if (window_gain_i !== e.gain) begin
            $error("window_gain: expected %0d, actual %0d", e.gain, window_gain_i);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) error_count_o <= error_count_o + errs;
    end
  end

endmodule

FILE: sim/cosine_sum_window_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-sum window generator testbench
// Drives sample indices through the window generator under a range of window
// types and lengths, with random idling on both sides, and leaves checking to
// the checker beside the block.
// ----------------------------------------------------------------------------
module cosine_sum_window_generator_core_tb;
  import csw_pkg::*;

  localparam int LATENCY = 46;
  localparam int CYCLE_LIMIT = 300000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [IDX_W-1:0]         sample_index_i;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [COEF_W-1:0] coefficient_o;
  logic [GAIN_W-1:0]        window_gain_o;
  int                       error_count;
  int                       pending;
  int                       cycle_count = 0;
  int                       sender_idle_pct;
  int                       receiver_idle_pct;
  int                       cur_len;

  cosine_sum_window_generator_core u_top (.*);

  csw_window_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .sample_index_i,
    .out_valid_i(out_valid_o), .out_stall_i, .coefficient_i(coefficient_o),
    .window_gain_i(window_gain_o), .error_count_o(error_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cosine_sum_window_generator_core_tb: done, errors");
      $finish;
    end
  end

  // Configuration changes only once every item in flight has come out.
  task automatic configure(logic [CFG_DATA_W-1:0] wt, logic [CFG_DATA_W-1:0] len);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_WINDOW_TYPE;
    cfg_wdata_i <= wt;
    @(posedge clk_i);
    cfg_idx_i <= REG_WINDOW_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len = (len == 0) ? 1 : len;
  endtask

  task automatic send_index(logic [IDX_W-1:0] n);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_index_i <= n;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] d_type[8] = '{0, 1, 2, 3, 4, 13'h1FFD, 6, 7};
    logic [CFG_DATA_W-1:0] d_len[8] = '{1024, 8, 4096, 0, 1, 8191, 2, 4096};
    logic [CFG_DATA_W-1:0] wt, len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    sample_index_i = '0;
    sender_idle_pct = 6;
    receiver_idle_pct = 74;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_index(12'd5);
    drain();

    for (int p = 0; p < 8; p++) begin
      configure(d_type[p], d_len[p]);
      send_index('0);
      send_index(12'hFFF);
      send_index(IDX_W'(cur_len / 2));
    end
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        sender_idle_pct = 74;
        receiver_idle_pct = 6;
      end else if (p == 8) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      wt = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 8191)) :
                                         CFG_DATA_W'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
        0: len = CFG_DATA_W'($urandom_range(0, 8191));
        1: len = CFG_DATA_W'(4096);
        default: len = CFG_DATA_W'($urandom_range(1, 64));
      endcase
      configure(wt, len);
      for (int i = 0; i < 32; i++) begin
        if (p == 6 && i == 16) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 1) == 0) send_index(IDX_W'($urandom_range(0, cur_len - 1)));
        else send_index(IDX_W'($urandom_range(0, 4095)));
      end
      drain();
    end

    if (error_count == 0) begin
      $display("cosine_sum_window_generator_core_tb: done, clean");
    end else begin
      $display("cosine_sum_window_generator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
